// ===== rtl/c_string_escape_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// C string escape decoder assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef C_STRING_ESCAPE_DECODER_DEFINES_SVH
`define C_STRING_ESCAPE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define CESC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CESC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CESC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CESC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/cesc_pkg.sv =====
// ----------------------------------------------------------------------------
// C string escape decoder package
// Mode and kind codes, queue command type, character tables.
// ----------------------------------------------------------------------------
package cesc_pkg;

  typedef enum logic [2:0] {
    MODE_LITERAL = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_OCTAL   = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_BAD     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_END       = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_TRUNC     = 2'd3
  } kind_t;

  typedef struct packed {
    logic        two;
    kind_t       kind;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  localparam logic [7:0] ESC_CHAR_RESET = 8'h5C;
  localparam logic [7:0] CHAR_0         = 8'h30;
  localparam logic [7:0] CHAR_7         = 8'h37;
  localparam logic [7:0] CHAR_9         = 8'h39;
  localparam logic [7:0] CHAR_A_LC      = 8'h61;
  localparam logic [7:0] CHAR_F_LC      = 8'h66;
  localparam logic [7:0] CHAR_X_LC      = 8'h78;
  localparam logic [7:0] CASE_BIT       = 8'h20;

  // {valid, value}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h74:   r = {1'b1, 8'h09};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h76:   r = {1'b1, 8'h0B};
      8'h66:   r = {1'b1, 8'h0C};
      8'h72:   r = {1'b1, 8'h0D};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h20:   r = {1'b1, 8'h20};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] d;
    lc = c | CASE_BIT;
    d  = lc - CHAR_A_LC + 8'd10;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      return {1'b1, c[3:0]};
    end else if (lc >= CHAR_A_LC && lc <= CHAR_F_LC) begin
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== rtl/cesc_if.sv =====
// ----------------------------------------------------------------------------
// C string escape decoder channels
// Valid/ready interfaces for input, result and configuration transfers.
// ----------------------------------------------------------------------------
interface cesc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;
  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface cesc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

interface cesc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cesc_front.sv =====
// ----------------------------------------------------------------------------
// C string escape decoder front end
// Accepts input items, tracks escape state, queues result commands.
// ----------------------------------------------------------------------------
module cesc_front (
  input  logic             clk,
  input  logic             rst,
  cesc_in_if.sink          in_ch,
  cesc_cfg_if.sink         cfg,
  input  logic             q_full,
  output cesc_pkg::push_t  push
);
  import cesc_pkg::*;

  logic [7:0] escape_char;
  mode_t      mode, mode_next;
  logic [7:0] value, value_next;
  logic [1:0] count, count_next;
  logic       fire;
  logic [7:0] c;
  logic [8:0] simple;
  logic [4:0] hex;
  logic       is_oct;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign simple      = simple_escape(c);
  assign hex         = hex_digit(c);
  assign is_oct      = (c >= CHAR_0) && (c <= CHAR_7);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_char <= ESC_CHAR_RESET;
    end else if (cfg.valid) begin
      escape_char <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_LITERAL;
      value <= 8'd0;
      count <= 2'd0;
    end else begin
      mode  <= mode_next;
      value <= value_next;
      count <= count_next;
    end
  end

  always_comb begin
    mode_next       = mode;
    value_next      = value;
    count_next      = count;
    push.valid      = 1'b0;
    push.cmd.two    = 1'b0;
    push.cmd.kind   = KIND_BYTE;
    push.cmd.byte0  = 8'd0;
    push.cmd.byte1  = c;
    if (fire) begin
      if (in_ch.func) begin
        push.valid = 1'b1;
        if (mode == MODE_BAD) begin
          push.cmd.kind = KIND_MALFORMED;
        end else if (mode == MODE_ESCAPE || mode == MODE_OCTAL || mode == MODE_HEX) begin
          push.cmd.kind = KIND_TRUNC;
        end else begin
          push.cmd.kind = KIND_END;
        end
        mode_next  = MODE_LITERAL;
        value_next = 8'd0;
        count_next = 2'd0;
      end else begin
        unique case (mode)
          MODE_ESCAPE: begin
            if (is_oct) begin
              value_next = {5'd0, c[2:0]};
              count_next = 2'd1;
              mode_next  = MODE_OCTAL;
            end else if (c == CHAR_X_LC) begin
              value_next = 8'd0;
              count_next = 2'd0;
              mode_next  = MODE_HEX;
            end else if (simple[8]) begin
              push.valid     = 1'b1;
              push.cmd.byte0 = simple[7:0];
              mode_next      = MODE_LITERAL;
            end else begin
              push.valid    = 1'b1;
              push.cmd.kind = KIND_MALFORMED;
              mode_next     = MODE_BAD;
            end
          end
          MODE_OCTAL, MODE_HEX: begin
            if (mode == MODE_OCTAL && is_oct) begin
              value_next = {value[4:0], c[2:0]};
              if (count >= 2'd2) begin
                push.valid     = 1'b1;
                push.cmd.byte0 = {value[4:0], c[2:0]};
                mode_next      = MODE_LITERAL;
              end else begin
                count_next = count + 2'd1;
              end
            end else if (mode == MODE_HEX && hex[4]) begin
              value_next = {value[3:0], hex[3:0]};
              if (count != 2'd0) begin
                push.valid     = 1'b1;
                push.cmd.byte0 = {value[3:0], hex[3:0]};
                mode_next      = MODE_LITERAL;
              end else begin
                count_next = 2'd1;
              end
            end else if (mode == MODE_HEX && count == 2'd0) begin
              push.valid    = 1'b1;
              push.cmd.kind = KIND_MALFORMED;
              mode_next     = MODE_BAD;
            end else begin
              push.valid     = 1'b1;
              push.cmd.byte0 = value;
              if (c == escape_char) begin
                mode_next = MODE_ESCAPE;
              end else begin
                push.cmd.two = 1'b1;
                mode_next    = MODE_LITERAL;
              end
            end
          end
          MODE_BAD: begin
          end
          default: begin
            mode_next = MODE_LITERAL;
            if (c == escape_char) begin
              mode_next = MODE_ESCAPE;
            end else begin
              push.valid     = 1'b1;
              push.cmd.byte0 = c;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/cesc_queue.sv =====
// ----------------------------------------------------------------------------
// C string escape decoder command queue
// Small FIFO of result commands between front and back ends.
// ----------------------------------------------------------------------------
module cesc_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  cesc_pkg::push_t  push,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output cesc_pkg::cmd_t   head
);
  import cesc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full       = (fill == CNT_FULL);
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cesc_back.sv =====
// ----------------------------------------------------------------------------
// C string escape decoder back end
// Expands queued commands into one or two results on the output register.
// ----------------------------------------------------------------------------
module cesc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cesc_pkg::cmd_t  head,
  output logic            pop,
  cesc_out_if.source      out_ch
);
  import cesc_pkg::*;

  logic       out_valid;
  kind_t      out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       take;

  assign take            = !out_valid || out_ch.ready;
  assign pop             = take && !pend_valid && head_valid;
  assign out_ch.valid    = out_valid;
  assign out_ch.kind     = out_kind;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (take) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= head_valid;
        pend_valid <= head_valid && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (pend_valid) begin
        out_kind <= KIND_BYTE;
        out_byte <= pend_byte;
        out_last <= 1'b1;
      end else if (head_valid) begin
        out_kind  <= head.kind;
        out_byte  <= head.byte0;
        out_last  <= !head.two;
        pend_byte <= head.byte1;
      end
    end
  end

endmodule

// ===== rtl/c_string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// C string escape decoder
// Decodes a byte stream with C-style escapes into bytes and stream status.
// ----------------------------------------------------------------------------
// channel  role    payload
// in_ch    sink    func, in_byte
// out_ch   source  kind, out_byte, last
// cfg      sink    data (escape byte)
//
// One input transfer per cycle unless the command queue is full; the front
// end decodes each item combinationally and queues any result as a command,
// which moves into the output register once that register is free; an item
// with two results holds the output for two transfers.
// Reset clears the escape state and sets the escape byte to backslash.
// Output stalls back up through the command queue to in_ch.ready.
// ----------------------------------------------------------------------------
`include "c_string_escape_decoder_defines.svh"

module c_string_escape_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  cesc_cfg_if.sink    cfg,
  cesc_in_if.sink     in_ch,
  cesc_out_if.source  out_ch
);
  import cesc_pkg::*;

  push_t push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  cmd_t  q_head;

  cesc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push)
  );

  cesc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  cesc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  `CESC_ASSERT_NXT(a_second_follows, clk, rst, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid && out_ch.kind == KIND_BYTE, "second result missing")
  `CESC_ASSERT_IMP(a_status_zero, clk, rst, out_ch.valid && out_ch.kind != KIND_BYTE, out_ch.out_byte == 8'd0 && out_ch.last, "status result malformed")
  `CESC_ASSERT_IMP(a_no_overflow, clk, rst, push.valid, !q_full, "command queue overflow")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C string escape decoder testbench
// Drives byte streams with simple, octal and hex escapes, malformed and cut
// off sequences through the input channel under several escape bytes, with
// random sender gaps and receiver stalls. A local decoder model predicts every
// result and each output transfer is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import cesc_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam logic [7:0] BACKSLASH     = 8'h5C;
  localparam logic [7:0] ASCII_0       = 8'h30;
  localparam logic [7:0] ASCII_7       = 8'h37;
  localparam logic [7:0] ASCII_9       = 8'h39;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_F = 8'h46;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_F = 8'h66;
  localparam logic [7:0] ASCII_X       = 8'h78;
  localparam logic [95:0] SIMPLE_LETTERS = {8'h61, 8'h62, 8'h74, 8'h6E, 8'h76, 8'h66,
                                            8'h72, 8'h5C, 8'h22, 8'h27, 8'h3F, 8'h20};

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  logic clk;
  logic rst;

  cesc_cfg_if cfg ();
  cesc_in_if  in_ch ();
  cesc_out_if out_ch ();

  c_string_escape_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  result_t    due_results[$];
  mode_t      mode_m = MODE_LITERAL;
  logic [7:0] value_m = 8'h00;
  logic [1:0] count_m = 2'd0;
  logic [7:0] escape_m = BACKSLASH;

  logic sender_gaps = 1'b1;
  logic receiver_stalls = 1'b1;
  logic moved;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   items_taken = 0;
  int   useful_items = 0;
  int   streams_closed = 0;
  int   results_checked = 0;
  int   malformed_seen = 0;
  int   truncated_seen = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [8:0] simple_code(logic [7:0] c);
    case (c)
      8'h61:   return {1'b1, 8'h07};
      8'h62:   return {1'b1, 8'h08};
      8'h74:   return {1'b1, 8'h09};
      8'h6E:   return {1'b1, 8'h0A};
      8'h76:   return {1'b1, 8'h0B};
      8'h66:   return {1'b1, 8'h0C};
      8'h72:   return {1'b1, 8'h0D};
      8'h5C, 8'h22, 8'h27, 8'h3F, 8'h20: return {1'b1, c};
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] hex_code(logic [7:0] c);
    if (c >= ASCII_0 && c <= ASCII_9) return {1'b1, c[3:0]};
    if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_F) return {1'b1, c[3:0] + 4'd9};
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  task automatic push_result(kind_t k, logic [7:0] d);
    result_t r;
    r.kind = k;
    r.data = (k == KIND_BYTE) ? d : 8'h00;
    r.last = 1'b0;
    if (k == KIND_MALFORMED) malformed_seen++;
    if (k == KIND_TRUNC) truncated_seen++;
    due_results.push_back(r);
  endtask

  task automatic take_literal(logic [7:0] c);
    if (c == escape_m) begin
      mode_m = MODE_ESCAPE;
    end else begin
      push_result(KIND_BYTE, c);
    end
  endtask

  task automatic decode_item(logic eos, logic [7:0] c);
    int         before_n;
    logic [8:0] simple;
    logic [4:0] hex;
    result_t    tail;
    before_n = due_results.size();
    items_taken++;
    if (eos) begin
      streams_closed++;
      useful_items++;
      case (mode_m)
        MODE_BAD:                      push_result(KIND_MALFORMED, 8'h00);
        MODE_ESCAPE, MODE_OCTAL, MODE_HEX: push_result(KIND_TRUNC, 8'h00);
        default:                       push_result(KIND_END, 8'h00);
      endcase
      mode_m = MODE_LITERAL;
      value_m = 8'h00;
      count_m = 2'd0;
    end else begin
      if (mode_m != MODE_BAD) useful_items++;
      case (mode_m)
        MODE_ESCAPE: begin
          if (c >= ASCII_0 && c <= ASCII_7) begin
            value_m = {5'd0, c[2:0]};
            count_m = 2'd1;
            mode_m = MODE_OCTAL;
          end else if (c == ASCII_X) begin
            value_m = 8'h00;
            count_m = 2'd0;
            mode_m = MODE_HEX;
          end else begin
            simple = simple_code(c);
            if (simple[8]) begin
              push_result(KIND_BYTE, simple[7:0]);
              mode_m = MODE_LITERAL;
            end else begin
              push_result(KIND_MALFORMED, 8'h00);
              mode_m = MODE_BAD;
            end
          end
        end
        MODE_OCTAL: begin
          if (c >= ASCII_0 && c <= ASCII_7) begin
            value_m = {value_m[4:0], c[2:0]};
            if (count_m >= 2'd2) begin
              push_result(KIND_BYTE, value_m);
              mode_m = MODE_LITERAL;
            end else begin
              count_m = count_m + 2'd1;
            end
          end else begin
            push_result(KIND_BYTE, value_m);
            mode_m = MODE_LITERAL;
            take_literal(c);
          end
        end
        MODE_HEX: begin
          hex = hex_code(c);
          if (hex[4]) begin
            value_m = {value_m[3:0], hex[3:0]};
            if (count_m != 2'd0) begin
              push_result(KIND_BYTE, value_m);
              mode_m = MODE_LITERAL;
            end else begin
              count_m = 2'd1;
            end
          end else if (count_m == 2'd0) begin
            push_result(KIND_MALFORMED, 8'h00);
            mode_m = MODE_BAD;
          end else begin
            push_result(KIND_BYTE, value_m);
            mode_m = MODE_LITERAL;
            take_literal(c);
          end
        end
        MODE_BAD: begin
        end
        default: begin
          mode_m = MODE_LITERAL;
          take_literal(c);
        end
      endcase
    end
    if (due_results.size() > before_n) begin
      tail = due_results.pop_back();
      tail.last = 1'b1;
      due_results.push_back(tail);
    end
  endtask

  task automatic check_result();
    result_t want;
    results_checked++;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with none pending: kind %0d byte %02h last %0b",
                 $time, out_ch.kind, out_ch.out_byte, out_ch.last);
    end else begin
      want = due_results.pop_front();
      if (out_ch.kind !== want.kind || out_ch.out_byte !== want.data ||
          out_ch.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                   $time, want.kind, want.data, want.last,
                   out_ch.kind, out_ch.out_byte, out_ch.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_m = MODE_LITERAL;
      value_m = 8'h00;
      count_m = 2'd0;
      escape_m = BACKSLASH;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg.valid && cfg.ready) begin
        escape_m = cfg.data;
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_item(in_ch.func, in_ch.in_byte);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------- receiver

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------- sender

  task automatic send_item(logic eos, logic [7:0] b);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.func = eos;
    in_ch.in_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v, logic upper);
    if (v < 4'd10) return ASCII_0 + {4'd0, v};
    return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + {4'd0, v} - 8'd10;
  endfunction

  task automatic wait_until_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_escape(logic [7:0] v);
    wait_until_idle();
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.data = v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_random_stream();
    int         n_tokens;
    int         pick;
    logic [7:0] b;
    n_tokens = $urandom_range(1, 20);
    repeat (n_tokens) begin
      pick = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      if (pick < 38) begin
        send_item(1'b0, b);
      end else if (pick < 58) begin
        send_item(1'b0, escape_m);
        send_item(1'b0, SIMPLE_LETTERS[8 * $urandom_range(0, 11) +: 8]);
      end else if (pick < 74) begin
        send_item(1'b0, escape_m);
        repeat ($urandom_range(1, 3)) send_item(1'b0, ASCII_0 + 8'($urandom_range(0, 7)));
      end else if (pick < 90) begin
        send_item(1'b0, escape_m);
        send_item(1'b0, ASCII_X);
        repeat ($urandom_range(1, 2))
          send_item(1'b0, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end else if (pick < 98) begin
        send_item(1'b0, b | 8'h80);
      end else begin
        send_item(1'b0, escape_m);
        send_item(1'b0, b);
      end
    end
    if ($urandom_range(0, 9) == 0) send_item(1'b0, escape_m);
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_random_phase(int n_items, logic gaps_in, logic stalls_out);
    int target;
    sender_gaps = gaps_in;
    receiver_stalls = stalls_out;
    target = items_taken + n_items;
    while (items_taken < target) send_random_stream();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_literals_and_simple();
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_text("\\ ");
  endtask

  task automatic test_numeric_escapes();
    send_text("\\777\\1\\xAb\\x7?");
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_stream_endings();
    send_text("\\xgz");
    send_item(1'b1, 8'hFF);
    send_text("\\12");
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_escape_settings();
    write_escape(8'h00);
    run_random_phase(250, 1'b1, 1'b1);
    write_escape(8'hFF);
    run_random_phase(250, 1'b1, 1'b0);
    write_escape(8'h25);
    run_random_phase(250, 1'b0, 1'b1);
    write_escape(ASCII_LOWER_A);
    run_random_phase(150, 1'b1, 1'b1);
    write_escape(BACKSLASH);
    run_random_phase(250, 1'b1, 1'b1);
  endtask

  task automatic test_steady_flow();
    run_random_phase(300, 1'b0, 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.in_byte = 8'h00;
    cfg.valid = 1'b0;
    cfg.data = 8'h00;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_literals_and_simple();
    test_numeric_escapes();
    test_stream_endings();
    test_escape_settings();
    test_steady_flow();
    wait_until_idle();
    repeat (8) @(negedge clk);
    $display("covered %0d input transfers (%0d decoded) in %0d streams, %0d results checked",
             items_taken, useful_items, streams_closed, results_checked);
    $display("escape bytes 5c 00 ff 25 61; %0d malformed and %0d truncated reports",
             malformed_seen, truncated_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
